// ===== sv/mcss_pkg.sv =====
package mcss_pkg;

    // Fixed geometry of the display.
    localparam int DIGITS      = 4;
    localparam int POS_W       = $clog2(DIGITS);
    localparam int BCD_W       = 4;
    localparam int RPC_W       = 16;
    localparam int HOUR_W      = 5;
    localparam int LINES_W     = 6;
    localparam int SEG_W       = 7;
    localparam int MODE_W      = 2;
    localparam int BTN_W       = 2;

    // Reset value of the rounds-per-count register.
    localparam logic [RPC_W-1:0] RPC_RESET = 16'd1500;

    // Mode codes, formed by the two button flags.
    localparam logic [MODE_W-1:0] MODE_IDLE      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_STOPWATCH = 2'd1;
    localparam logic [MODE_W-1:0] MODE_H24       = 2'd2;
    localparam logic [MODE_W-1:0] MODE_H12       = 2'd3;

    // All digits off.
    localparam logic [LINES_W-1:0] LINES_OFF = 6'h3F;

    // State that the display logic reads for one scan slot.
    typedef struct packed {
        logic [MODE_W-1:0]             mode;
        logic [POS_W-1:0]              pos;
        logic [DIGITS-1:0][BCD_W-1:0]  sw_bcd;
        logic [HOUR_W-1:0]             hour;
        logic [2:0]                    min_tens;
        logic [BCD_W-1:0]              min_units;
    } mcss_disp_t;

    // What one scan slot drives onto the display.
    typedef struct packed {
        logic [LINES_W-1:0] digit_lines;
        logic [SEG_W-1:0]   segments;
        logic               am_lamp;
        logic               pm_lamp;
    } mcss_disp_out_t;

    // Segment patterns a..g for the decimal digits.
    function automatic logic [SEG_W-1:0] seg_of(input logic [BCD_W-1:0] digit);
        logic [SEG_W-1:0] pat;
        unique case (digit)
            4'd0:    pat = 7'h3F;
            4'd1:    pat = 7'h06;
            4'd2:    pat = 7'h5B;
            4'd3:    pat = 7'h4F;
            4'd4:    pat = 7'h66;
            4'd5:    pat = 7'h6D;
            4'd6:    pat = 7'h7D;
            4'd7:    pat = 7'h07;
            4'd8:    pat = 7'h7F;
            4'd9:    pat = 7'h6F;
            default: pat = 7'h00;
        endcase
        return pat;
    endfunction

    // Active-low digit enable; positions 0..3 drive bits 0, 3, 4 and 5.
    function automatic logic [LINES_W-1:0] lines_of(input logic [POS_W-1:0] pos);
        logic [LINES_W-1:0] lines;
        unique case (pos)
            2'd0:    lines = 6'h3E;
            2'd1:    lines = 6'h37;
            2'd2:    lines = 6'h2F;
            default: lines = 6'h1F;
        endcase
        return lines;
    endfunction

endpackage

// ===== sv/mcss_display.sv =====
module mcss_display (
    input  mcss_pkg::mcss_disp_t     st,
    output mcss_pkg::mcss_disp_out_t disp
);
    import mcss_pkg::*;

    logic [HOUR_W-1:0] hour_12;
    logic [HOUR_W-1:0] hour_sel;
    logic [1:0]        hour_tens;
    logic [HOUR_W-1:0] hour_rest;
    logic [BCD_W-1:0]  digit;
    logic              pm;

    // Twelve-hour form: hour 12 stays 12, others fold modulo 12.
    always_comb begin
        if (st.hour == 5'd12) begin
            hour_12 = 5'd12;
        end else if (st.hour > 5'd12) begin
            hour_12 = st.hour - 5'd12;
        end else begin
            hour_12 = st.hour;
        end
        hour_sel = (st.mode == MODE_H12) ? hour_12 : st.hour;
    end

    // Split the hour into its two decimal digits.
    always_comb begin
        if (hour_sel >= 5'd20) begin
            hour_tens = 2'd2;
            hour_rest = hour_sel - 5'd20;
        end else if (hour_sel >= 5'd10) begin
            hour_tens = 2'd1;
            hour_rest = hour_sel - 5'd10;
        end else begin
            hour_tens = 2'd0;
            hour_rest = hour_sel;
        end
    end

    // Pick the digit for the current scan position; position 0 is the units digit.
    always_comb begin
        if (st.mode == MODE_STOPWATCH) begin
            digit = st.sw_bcd[st.pos];
        end else begin
            unique case (st.pos)
                2'd0:    digit = st.min_units;
                2'd1:    digit = {1'b0, st.min_tens};
                2'd2:    digit = hour_rest[BCD_W-1:0];
                default: digit = {2'b00, hour_tens};
            endcase
        end
    end

    assign pm = (st.mode == MODE_H12) && (st.hour > 5'd12);

    // Idle blanks everything; active modes light one digit.
    always_comb begin
        if (st.mode == MODE_IDLE) begin
            disp.digit_lines = LINES_OFF;
            disp.segments    = '0;
            disp.am_lamp     = 1'b0;
            disp.pm_lamp     = 1'b0;
        end else begin
            disp.digit_lines = lines_of(st.pos);
            disp.segments    = seg_of(digit);
            disp.am_lamp     = (st.mode == MODE_H12) && !pm;
            disp.pm_lamp     = pm;
        end
    end

endmodule

// ===== sv/multimode_clock_seven_segment_scan.sv =====
// Channel  | Direction | Signals                          | Contents
// ---------+-----------+----------------------------------+------------------------------------
// s_       | in        | s_tvalid, s_tready, s_tdata[7:0] | one scan slot: button levels
// m_       | out       | m_tvalid, m_tready, m_tdata,     | digit lines, segments, lamps; mode
//          |           | m_tuser                          |
// cfg_     | in        | cfg_valid, cfg_ready, cfg_data   | rounds per count advance
//
// For each slot, button edges, display decode and counter update are
// one pass of logic between the state registers and the result register.
// A new slot is taken every cycle while the result register is empty or being drained.
// Reset (aresetn low, synchronous) sets both buttons released, idle mode, cleared
// counters and rounds per count to 1500. A stalled result holds; input then waits.
module multimode_clock_seven_segment_scan (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration transfer: rounds_per_count.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    // Input slot.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [1:0] button_levels, [7:2] zero
    // Result slot.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [5:0] digit_lines, [12:6] segments, [13] am_lamp,
                                   // [14] pm_lamp, [15] zero
    output logic [1:0]  m_tuser    // [1:0] mode
);
    import mcss_pkg::*;

    logic [RPC_W-1:0]             rpc_reg;
    logic [BTN_W-1:0]             last_levels_reg;
    logic [MODE_W-1:0]            mode_flags_reg;
    logic [DIGITS-1:0][BCD_W-1:0] sw_reg;
    logic [HOUR_W-1:0]            hour_reg;
    logic [2:0]                   min_tens_reg;
    logic [BCD_W-1:0]             min_units_reg;
    logic [POS_W-1:0]             pos_reg;
    logic [RPC_W-1:0]             rounds_reg;
    logic                         m_valid_reg;
    logic [15:0]                  m_data_reg;
    logic [1:0]                   m_user_reg;

    logic [MODE_W-1:0]            mode_flags_next;
    logic [DIGITS-1:0][BCD_W-1:0] sw_next;
    logic [HOUR_W-1:0]            hour_next;
    logic [2:0]                   min_tens_next;
    logic [BCD_W-1:0]             min_units_next;
    logic [POS_W-1:0]             pos_next;
    logic [RPC_W-1:0]             rounds_next;

    logic                         s_accept;
    logic [BTN_W-1:0]             levels;
    logic [BTN_W-1:0]             falls;
    logic                         toggle;
    logic [DIGITS-1:0][BCD_W-1:0] sw_cur;
    logic [HOUR_W-1:0]            hour_cur;
    logic [2:0]                   min_tens_cur;
    logic [BCD_W-1:0]             min_units_cur;
    logic [POS_W-1:0]             pos_cur;
    logic [RPC_W-1:0]             rounds_cur;
    logic [RPC_W-1:0]             rounds_inc;
    logic [RPC_W-1:0]             limit;
    logic                         advance;
    logic                         carry;
    mcss_disp_t                   disp_st;
    mcss_disp_out_t               disp;

    assign s_accept  = s_tvalid && s_tready;
    assign s_tready  = !m_valid_reg || m_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_user_reg;

    // A falling edge on a button toggles its flag and restarts all counting.
    assign levels = s_tdata[BTN_W-1:0];
    assign falls  = ~levels & last_levels_reg;
    assign toggle = |falls;

    always_comb begin
        mode_flags_next = mode_flags_reg ^ falls;
        sw_cur          = toggle ? '0 : sw_reg;
        hour_cur        = toggle ? '0 : hour_reg;
        min_tens_cur    = toggle ? '0 : min_tens_reg;
        min_units_cur   = toggle ? '0 : min_units_reg;
        pos_cur         = toggle ? '0 : pos_reg;
        rounds_cur      = toggle ? '0 : rounds_reg;
    end

    // Display decode of this slot in the new mode.
    always_comb begin
        disp_st.mode      = mode_flags_next;
        disp_st.pos       = pos_cur;
        disp_st.sw_bcd    = sw_cur;
        disp_st.hour      = hour_cur;
        disp_st.min_tens  = min_tens_cur;
        disp_st.min_units = min_units_cur;
    end

    mcss_display u_display (
        .st   (disp_st),
        .disp (disp)
    );

    // Scan advance; a count advances when enough full rounds have gone by.
    always_comb begin
        limit       = (rpc_reg == '0) ? {{(RPC_W-1){1'b0}}, 1'b1} : rpc_reg;
        rounds_inc  = rounds_cur + 1'b1;
        pos_next    = pos_cur;
        rounds_next = rounds_cur;
        advance     = 1'b0;
        if (mode_flags_next != MODE_IDLE) begin
            pos_next = pos_cur + 1'b1;
            if (pos_cur == POS_W'(DIGITS - 1)) begin
                if (rounds_inc >= limit) begin
                    rounds_next = '0;
                    advance     = 1'b1;
                end else begin
                    rounds_next = rounds_inc;
                end
            end
        end
    end

    // Stopwatch as a decimal counter; all nines wraps to zero.
    always_comb begin
        sw_next = sw_cur;
        carry   = advance && (mode_flags_next == MODE_STOPWATCH);
        for (int i = 0; i < DIGITS; i++) begin
            if (carry) begin
                if (sw_cur[i] == 4'd9) begin
                    sw_next[i] = '0;
                end else begin
                    sw_next[i] = sw_cur[i] + 1'b1;
                    carry      = 1'b0;
                end
            end
        end
    end

    // Clock: minutes roll into hours, 23:59 rolls to 00:00.
    always_comb begin
        hour_next      = hour_cur;
        min_tens_next  = min_tens_cur;
        min_units_next = min_units_cur;
        if (advance && (mode_flags_next != MODE_STOPWATCH)) begin
            if (min_units_cur == 4'd9) begin
                min_units_next = '0;
                if (min_tens_cur == 3'd5) begin
                    min_tens_next = '0;
                    hour_next     = (hour_cur == 5'd23) ? '0 : hour_cur + 1'b1;
                end else begin
                    min_tens_next = min_tens_cur + 1'b1;
                end
            end else begin
                min_units_next = min_units_cur + 1'b1;
            end
        end
    end

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rpc_reg <= RPC_RESET;
        end else if (cfg_valid && cfg_ready) begin
            rpc_reg <= cfg_data;
        end
    end

    // State update on each accepted slot.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_levels_reg <= '1;
            mode_flags_reg  <= MODE_IDLE;
            sw_reg          <= '0;
            hour_reg        <= '0;
            min_tens_reg    <= '0;
            min_units_reg   <= '0;
            pos_reg         <= '0;
            rounds_reg      <= '0;
        end else if (s_accept) begin
            last_levels_reg <= levels;
            mode_flags_reg  <= mode_flags_next;
            sw_reg          <= sw_next;
            hour_reg        <= hour_next;
            min_tens_reg    <= min_tens_next;
            min_units_reg   <= min_units_next;
            pos_reg         <= pos_next;
            rounds_reg      <= rounds_next;
        end
    end

    // Result register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_data_reg <= {1'b0, disp.pm_lamp, disp.am_lamp, disp.segments, disp.digit_lines};
            m_user_reg <= mode_flags_next;
        end
    end

endmodule

// ===== sv/mcss_checker.sv =====
module mcss_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [1:0]  m_tuser
);
    import mcss_pkg::*;

    // Idle results blank the display.
    a_idle_blank: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == MODE_IDLE) |-> (m_tdata[5:0] == LINES_OFF)
            && (m_tdata[12:6] == '0))
        else $error("idle result not blank");

    // Active results light exactly one of the four wired digits.
    a_one_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != MODE_IDLE) |-> ($countones(m_tdata[5:0]) == 5)
            && m_tdata[1] && m_tdata[2])
        else $error("active result does not select exactly one digit");

    // Lamps are off outside twelve-hour mode and never both on.
    a_lamps: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[13] && m_tdata[14])
            && ((m_tuser == MODE_H12) || (!m_tdata[13] && !m_tdata[14])))
        else $error("lamp state wrong for mode");

    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Input is taken whenever the output side is free.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

endmodule

bind multimode_clock_seven_segment_scan mcss_checker u_mcss_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
